### rtl/pnv_pkg.sv
package pnv_pkg;

  localparam int unsigned CH_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START_RULE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_RULE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_RULE = 2'd2;

  localparam logic signed [1:0] RULE_MUST = 2'sb01;
  localparam logic signed [1:0] RULE_MUST_NOT = 2'sb11;

  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_DEL = 8'h7f;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CH_W-1:0] CH_THREE = 8'h33;
  localparam logic [CH_W-1:0] CH_SEVEN = 8'h37;

  typedef enum logic [3:0] {
    ESC_NONE = 4'b0001,
    ESC_OPEN = 4'b0010,
    ESC_OCT1 = 4'b0100,
    ESC_OCT2 = 4'b1000
  } esc_e;

  typedef struct packed {
    esc_e       esc;
    logic [1:0] oct_hi;
    logic [2:0] oct_mid;
    logic       saw_wild;
    logic       failed;
    logic       at_start;
  } pnv_state_t;

  localparam pnv_state_t STATE_RST = '{
    esc: ESC_NONE, oct_hi: 2'd0, oct_mid: 3'd0,
    saw_wild: 1'b0, failed: 1'b0, at_start: 1'b1
  };

  typedef struct packed {
    logic signed [1:0] start_rule;
    logic signed [1:0] wildcard_rule;
    logic signed [1:0] end_rule;
  } pnv_rules_t;

  function automatic logic is_wild(input logic [CH_W-1:0] c);
    return (c == 8'h24) || (c == 8'h2b) || (c == 8'h3f) || (c == 8'h2a) ||
           (c == 8'h40) || (c == 8'h78) || (c == 8'h58) || (c == 8'h61) ||
           (c == 8'h41) || (c == 8'h2d);
  endfunction

  function automatic logic slash_ok(input logic signed [1:0] rule,
                                    input logic [CH_W-1:0] c,
                                    input logic present);
    logic slash;
    slash = present && (c == CH_SLASH);
    if (rule == RULE_MUST) return slash;
    if (rule == RULE_MUST_NOT) return !slash;
    return 1'b1;
  endfunction

endpackage

### rtl/pnv_in_if.sv
interface pnv_in_if;
  logic                     valid;
  logic                     ready;
  logic [pnv_pkg::CH_W-1:0] ch;
  logic                     has_char;
  logic                     last;

  modport source (output valid, ch, has_char, last, input ready);
  modport sink (input valid, ch, has_char, last, output ready);
endinterface

### rtl/pnv_out_if.sv
interface pnv_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, valid_res, input ready);
  modport sink (input valid, valid_res, output ready);
endinterface

### rtl/pnv_step.sv
module pnv_step (
  input  pnv_pkg::pnv_state_t       state_i,
  input  pnv_pkg::pnv_rules_t       rules_i,
  input  logic [pnv_pkg::CH_W-1:0]  ch_i,
  input  logic                      has_char_i,
  input  logic                      last_i,
  output pnv_pkg::pnv_state_t       state_o,
  output logic                      ok_o
);
  import pnv_pkg::*;

  pnv_state_t       st;
  logic [CH_W-1:0]  oct_val;
  logic             is_oct;

  assign is_oct = (ch_i >= CH_ZERO) && (ch_i <= CH_SEVEN);
  assign oct_val = {state_i.oct_hi, state_i.oct_mid, ch_i[2:0]};

  always_comb begin
    st = state_i;
    if (has_char_i) begin
      if (state_i.at_start) begin
        if (!slash_ok(rules_i.start_rule, ch_i, 1'b1)) st.failed = 1'b1;
        st.at_start = 1'b0;
      end
      unique case (state_i.esc)
        ESC_NONE: begin
          if (ch_i == CH_BSLASH) begin
            st.esc = ESC_OPEN;
          end else if (ch_i <= CH_SPACE || ch_i >= CH_DEL) begin
            st.failed = 1'b1;
          end
        end
        ESC_OPEN: begin
          st.esc = ESC_NONE;
          if (ch_i == CH_BSLASH) begin
            st.esc = ESC_NONE;
          end else if (is_wild(ch_i)) begin
            if (rules_i.wildcard_rule == RULE_MUST_NOT) st.failed = 1'b1;
            else st.saw_wild = 1'b1;
          end else if (ch_i >= CH_ZERO && ch_i <= CH_THREE) begin
            st.oct_hi = ch_i[1:0];
            st.esc = ESC_OCT1;
          end else begin
            st.failed = 1'b1;
          end
        end
        ESC_OCT1: begin
          if (is_oct) begin
            st.oct_mid = ch_i[2:0];
            st.esc = ESC_OCT2;
          end else begin
            st.failed = 1'b1;
            st.esc = ESC_NONE;
          end
        end
        ESC_OCT2: begin
          st.esc = ESC_NONE;
          if (!(is_oct && oct_val != '0 && (oct_val <= CH_SPACE || oct_val >= CH_DEL))) begin
            st.failed = 1'b1;
          end
        end
        default: begin
          st.esc = ESC_NONE;
          st.failed = 1'b1;
        end
      endcase
    end else if (state_i.at_start) begin
      if (last_i && !slash_ok(rules_i.start_rule, ch_i, 1'b0)) st.failed = 1'b1;
    end else begin
      st.failed = 1'b1;
    end

    ok_o = !st.failed && (st.esc == ESC_NONE) &&
           slash_ok(rules_i.end_rule, ch_i, has_char_i) &&
           !(rules_i.wildcard_rule == RULE_MUST && !st.saw_wild);

    state_o = last_i ? STATE_RST : st;
  end

endmodule

### rtl/path_name_validator_unit.sv
// Channel   Dir  Payload                  Transfer
// in_if     in   ch, has_char, last       valid & ready
// out_if    out  valid_res                valid & ready
// cfg       in   cfg_idx_i, cfg_wdata_i   cfg_we_i
//
// One byte per cycle while the input is not stalled: input register, combinational escape/rule logic, result register.
// A result is loaded into the result register when its last byte moves on from the input register.
// Input stalls only when a last byte waits while the result register is still held.
// Reset clears the rules to "either" and the string state to start of name.
module path_name_validator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pnv_in_if.sink                              in_if,
  pnv_out_if.source                           out_if,
  input  logic                                cfg_we_i,
  input  logic [pnv_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic signed [pnv_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import pnv_pkg::*;

  pnv_rules_t       rules_q;
  pnv_state_t       state_q, state_d;
  logic             s1_valid_q;
  logic [CH_W-1:0]  s1_ch_q;
  logic             s1_has_q;
  logic             s1_last_q;
  logic             s1_adv;
  logic             res_valid_q;
  logic             res_q;
  logic             ok;
  logic             fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_RULE:    rules_q.start_rule <= cfg_wdata_i;
        CFG_WILDCARD_RULE: rules_q.wildcard_rule <= cfg_wdata_i;
        CFG_END_RULE:      rules_q.end_rule <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s1_adv = !s1_valid_q || !s1_last_q || !res_valid_q || out_if.ready;
  assign in_if.ready = s1_adv;
  assign fire = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && s1_adv) begin
      s1_ch_q   <= in_if.ch;
      s1_has_q  <= in_if.has_char;
      s1_last_q <= in_if.last;
    end
  end

  pnv_step u_step (
    .state_i    (state_q),
    .rules_i    (rules_q),
    .ch_i       (s1_ch_q),
    .has_char_i (s1_has_q),
    .last_i     (s1_last_q),
    .state_o    (state_d),
    .ok_o       (ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RST;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (fire && s1_last_q) begin
      res_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && s1_last_q) res_q <= ok;
  end

  assign out_if.valid     = res_valid_q;
  assign out_if.valid_res = res_q;

  a_res_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(s1_valid_q && s1_last_q))
    else $error("result without a last byte");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (s1_valid_q && s1_last_q && res_valid_q && !out_if.ready))
    else $error("input stalled without a pending result");

  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s1_last_q) |=> (state_q == STATE_RST))
    else $error("string state not cleared after last byte");

endmodule
